>>> hdl/mahd_pkg.sv
// ----------------------------------------------------------------------------
// MPEG audio header decoder package
// Field widths, header codes, rate tables and reciprocal constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mahd_pkg;

   localparam int unsigned HeaderWidth  = 32;
   localparam int unsigned VersionWidth = 2;
   localparam int unsigned LayerWidth   = 2;
   localparam int unsigned KbpsWidth    = 9;
   localparam int unsigned HzWidth      = 16;
   localparam int unsigned ModeWidth    = 2;
   localparam int unsigned BytesWidth   = 12;
   localparam int unsigned SpfWidth     = 11;
   localparam int unsigned CoefWidth    = 20;
   localparam int unsigned NumerWidth   = 27;
   localparam int unsigned RecipWidth   = 30;
   localparam int unsigned RecipShift   = 44;

   // version code in header
   localparam logic [1:0] VerCodeMpeg25    = 2'b00;
   localparam logic [1:0] VerCodeReserved  = 2'b01;
   localparam logic [1:0] VerCodeMpeg2     = 2'b10;
   localparam logic [1:0] VerCodeMpeg1     = 2'b11;
   // layer code in header
   localparam logic [1:0] LayCodeReserved  = 2'b00;
   localparam logic [1:0] LayCode3         = 2'b01;
   localparam logic [1:0] LayCode2         = 2'b10;
   localparam logic [1:0] LayCode1         = 2'b11;
   localparam logic [1:0] SidxReserved     = 2'b11;
   localparam logic [3:0] BidxFree         = 4'h0;
   localparam logic [3:0] BidxBad          = 4'hF;

   // decoded version / layer numbers
   localparam logic [1:0] VerMpeg1  = 2'd1;
   localparam logic [1:0] VerMpeg2  = 2'd2;
   localparam logic [1:0] VerMpeg25 = 2'd3;
   localparam logic [1:0] Layer1    = 2'd1;
   localparam logic [1:0] Layer2    = 2'd2;
   localparam logic [1:0] Layer3    = 2'd3;

   localparam logic [SpfWidth-1:0] Spf384  = 11'd384;
   localparam logic [SpfWidth-1:0] Spf576  = 11'd576;
   localparam logic [SpfWidth-1:0] Spf1152 = 11'd1152;

   localparam logic [CoefWidth-1:0] CoefL1    = 20'd12000;
   localparam logic [CoefWidth-1:0] CoefL2    = 20'd144000;
   localparam logic [CoefWidth-1:0] CoefL3Low = 20'd72000;

   localparam logic [HzWidth-1:0] Hz44100 = 16'd44100;
   localparam logic [HzWidth-1:0] Hz48000 = 16'd48000;
   localparam logic [HzWidth-1:0] Hz32000 = 16'd32000;

   localparam logic [63:0] RecipOne = 64'd1 << RecipShift;
   localparam logic [RecipWidth-1:0] Recip44100 =
      RecipWidth'((RecipOne + 64'd44099) / 64'd44100);
   localparam logic [RecipWidth-1:0] Recip48000 =
      RecipWidth'((RecipOne + 64'd47999) / 64'd48000);
   localparam logic [RecipWidth-1:0] Recip32000 =
      RecipWidth'((RecipOne + 64'd31999) / 64'd32000);

   typedef logic [KbpsWidth-1:0] kbps_row_type [16];

   localparam kbps_row_type KbpsV1L1 = '{
      9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
   localparam kbps_row_type KbpsV1L2 = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
   localparam kbps_row_type KbpsV1L3 = '{
      9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
   localparam kbps_row_type KbpsV2L1 = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
   localparam kbps_row_type KbpsV2L23 = '{
      9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

endpackage

`default_nettype wire

>>> hdl/mahd_req_if.sv
// ----------------------------------------------------------------------------
// MPEG audio header decoder request channel
// Valid/ready channel carrying one raw header word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mahd_req_if
   import mahd_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [HeaderWidth-1:0] header_word;

   modport source (output valid, output header_word, input ready);
   modport sink   (input valid, input header_word, output ready);
endinterface

`default_nettype wire

>>> hdl/mahd_rsp_if.sv
// ----------------------------------------------------------------------------
// MPEG audio header decoder response channel
// Valid/ready channel carrying the decoded header fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface mahd_rsp_if
   import mahd_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic                    valid_res;
   logic [VersionWidth-1:0] mpeg_version;
   logic [LayerWidth-1:0]   layer_number;
   logic [KbpsWidth-1:0]    bitrate_kbps;
   logic [HzWidth-1:0]      sample_rate_hz;
   logic                    padding;
   logic [ModeWidth-1:0]    channel_mode;
   logic [BytesWidth-1:0]   frame_bytes;
   logic [SpfWidth-1:0]     samples_per_frame;

   modport source (output valid, output valid_res, output mpeg_version,
                   output layer_number, output bitrate_kbps, output sample_rate_hz,
                   output padding, output channel_mode, output frame_bytes,
                   output samples_per_frame, input ready);
   modport sink   (input valid, input valid_res, input mpeg_version,
                   input layer_number, input bitrate_kbps, input sample_rate_hz,
                   input padding, input channel_mode, input frame_bytes,
                   input samples_per_frame, output ready);
endinterface

`default_nettype wire

>>> hdl/mpeg_audio_header_decoder_top.sv
// ----------------------------------------------------------------------------
// MPEG audio header decoder
// Checks one 32-bit frame header word per cycle unless stalled.
//
// req_if carries one header word per accepted word; rsp_if returns one
// decoded word per request, in order. An illegal header gives valid_res = 0
// and all other fields zero.
// Throughput: one word per cycle unless rsp_if stalls. Four pipeline
// stages (decode/tables, coefficient multiply, reciprocal multiply, frame
// length/output).
// Frame length uses an exact reciprocal multiply by the base sample rate.
// Reset clears all stage valid bits; the pipeline is empty afterwards.
// When rsp_if.ready is low with a word in the output register, the whole
// pipeline holds and req_if.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg_audio_header_decoder_top
   import mahd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   mahd_req_if.sink    req_if,
   mahd_rsp_if.source  rsp_if
);

   typedef struct packed {
      logic                    legal;
      logic [VersionWidth-1:0] ver;
      logic [LayerWidth-1:0]   lay;
      logic [KbpsWidth-1:0]    kbps;
      logic [HzWidth-1:0]      hz;
      logic                    pad;
      logic [ModeWidth-1:0]    mode;
      logic [SpfWidth-1:0]     spf;
   } fields_type;

   logic advance;

   // stage 1
   logic                   v1_ff, v1_in;
   fields_type             f1_ff, f1_in;
   logic [CoefWidth-1:0]   coef1_ff, coef1_in;
   logic [1:0]             sidx1_ff, sidx1_in;
   // stage 2
   logic                   v2_ff;
   fields_type             f2_ff;
   logic [NumerWidth-1:0]  numer2_ff, numer2_in;
   logic [RecipWidth-1:0]  recip2_ff, recip2_in;
   // stage 3
   logic                   v3_ff;
   fields_type             f3_ff;
   logic [BytesWidth-1:0]  quot3_ff, quot3_in;
   logic [NumerWidth+RecipWidth-1:0] prod3;
   // stage 4
   logic                   v4_ff;
   fields_type             f4_ff;
   logic [BytesWidth-1:0]  bytes4_ff, bytes4_in;
   logic [BytesWidth-1:0]  qpad3;

   assign advance      = ~v4_ff | rsp_if.ready;
   assign req_if.ready = advance;

   // ---- stage 1: check and table decode
   always_comb begin
      logic [HeaderWidth-1:0]  h;
      logic [1:0]              vi;
      logic [HzWidth-1:0]      base_hz;
      logic [CoefWidth-1:0]    coef;
      h        = req_if.header_word;
      f1_in    = '0;
      coef1_in = '0;
      sidx1_in = h[11:10];
      v1_in    = req_if.valid;
      vi       = 2'd0;
      base_hz  = '0;
      coef     = '0;

      f1_in.legal = (&h[31:21]) && (h[20:19] != VerCodeReserved) &&
                    (h[18:17] != LayCodeReserved) && (h[15:12] != BidxBad) &&
                    (h[15:12] != BidxFree) && (h[11:10] != SidxReserved);

      unique case (h[20:19])
         VerCodeMpeg1:    begin f1_in.ver = VerMpeg1;  vi = 2'd0; end
         VerCodeMpeg2:    begin f1_in.ver = VerMpeg2;  vi = 2'd1; end
         VerCodeMpeg25:   begin f1_in.ver = VerMpeg25; vi = 2'd2; end
         VerCodeReserved: begin f1_in.ver = '0;        vi = 2'd0; end
      endcase

      unique case (h[18:17])
         LayCode1:        f1_in.lay = Layer1;
         LayCode2:        f1_in.lay = Layer2;
         LayCode3:        f1_in.lay = Layer3;
         LayCodeReserved: f1_in.lay = '0;
      endcase

      priority if (vi == 2'd0) begin
         unique case (f1_in.lay)
            Layer1:  f1_in.kbps = KbpsV1L1[h[15:12]];
            Layer2:  f1_in.kbps = KbpsV1L2[h[15:12]];
            default: f1_in.kbps = KbpsV1L3[h[15:12]];
         endcase
      end else if (f1_in.lay == Layer1) begin
         f1_in.kbps = KbpsV2L1[h[15:12]];
      end else begin
         f1_in.kbps = KbpsV2L23[h[15:12]];
      end

      unique case (h[11:10])
         2'd0:    base_hz = Hz44100;
         2'd1:    base_hz = Hz48000;
         default: base_hz = Hz32000;
      endcase
      f1_in.hz = base_hz >> vi;

      unique case (f1_in.lay)
         Layer1:  begin coef = CoefL1; f1_in.spf = Spf384; end
         Layer2:  begin coef = CoefL2; f1_in.spf = Spf1152; end
         default: begin
            coef      = (vi == 2'd0) ? CoefL2 : CoefL3Low;
            f1_in.spf = (vi == 2'd0) ? Spf1152 : Spf576;
         end
      endcase
      coef1_in   = coef << vi;
      f1_in.pad  = h[9];
      f1_in.mode = h[7:6];

      if (!f1_in.legal) begin
         f1_in    = '0;
         coef1_in = '0;
      end
   end

   // ---- stage 2: numerator and reciprocal select
   assign numer2_in = NumerWidth'(coef1_ff) * NumerWidth'(f1_ff.kbps);

   always_comb begin
      unique case (sidx1_ff)
         2'd0:    recip2_in = Recip44100;
         2'd1:    recip2_in = Recip48000;
         default: recip2_in = Recip32000;
      endcase
   end

   // ---- stage 3: quotient by reciprocal multiply
   assign prod3    = numer2_ff * recip2_ff;
   assign quot3_in = prod3[RecipShift+BytesWidth-1:RecipShift];

   // ---- stage 4: frame length
   assign qpad3     = quot3_ff + BytesWidth'(f3_ff.pad);
   assign bytes4_in = (f3_ff.lay == Layer1) ? (qpad3 << 2) : qpad3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_ff     <= f1_in;
         coef1_ff  <= coef1_in;
         sidx1_ff  <= sidx1_in;
         f2_ff     <= f1_ff;
         numer2_ff <= numer2_in;
         recip2_ff <= recip2_in;
         f3_ff     <= f2_ff;
         quot3_ff  <= quot3_in;
         f4_ff     <= f3_ff;
         bytes4_ff <= bytes4_in;
      end
   end

   assign rsp_if.valid             = v4_ff;
   assign rsp_if.valid_res         = f4_ff.legal;
   assign rsp_if.mpeg_version      = f4_ff.ver;
   assign rsp_if.layer_number      = f4_ff.lay;
   assign rsp_if.bitrate_kbps      = f4_ff.kbps;
   assign rsp_if.sample_rate_hz    = f4_ff.hz;
   assign rsp_if.padding           = f4_ff.pad;
   assign rsp_if.channel_mode      = f4_ff.mode;
   assign rsp_if.frame_bytes       = bytes4_ff;
   assign rsp_if.samples_per_frame = f4_ff.spf;

endmodule

`default_nettype wire
